>>> hw/rtl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_ACK   = 3'd5,
      CMD_NACK  = 3'd6,
      CMD_WAIT  = 3'd7
   } cmd_type;

   localparam logic [2:0] PH_POLL  = 3'd6;
   localparam logic [2:0] PH_FINAL = 3'd7;

   localparam logic CSR_DELAY_UNIT  = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [15:0] DELAY_UNIT_RESET  = 16'd32;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

   typedef struct packed {
      logic scl;
      logic en;
      logic sda;
   } line_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_enable;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_failed;
   } rsp_type;

endpackage

>>> hw/rtl/i2cmbe_core.sv
// ----------------------------------------------------------------------------
// i2cmbe_core
// Bus sequencer state, timing counters and configuration registers; one
// tick of the engine is taken per accepted request beat.
// ----------------------------------------------------------------------------
module i2cmbe_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  i2cmbe_pkg::cmd_type  action,
   input  logic [7:0]           tx_byte,
   input  logic                 sda_level,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   output i2cmbe_pkg::rsp_type  result
);

   typedef struct packed {
      i2cmbe_pkg::line_type lines;
      logic [17:0]          dcnt;
   } enter_type;

   logic [15:0]          delay_unit_ff;
   logic [7:0]           ack_timeout_ff;
   i2cmbe_pkg::cmd_type  cmd_ff, cmd_in;
   logic [2:0]           phase_ff, phase_in;
   logic [17:0]          dcnt_ff, dcnt_in;
   logic [3:0]           bcnt_ff, bcnt_in;
   logic [7:0]           shift_ff, shift_in;
   logic [7:0]           poll_ff, poll_in;
   i2cmbe_pkg::line_type lines_ff, lines_in;
   logic [7:0]           rx_ff, rx_in;
   logic                 fail_ff, fail_in;

   logic [15:0]          unit;
   enter_type            ent;
   logic [2:0]           next_phase;
   i2cmbe_pkg::line_type out_lines;
   logic                 busy, done;

   function automatic enter_type enter_fn(i2cmbe_pkg::cmd_type cmd, logic [2:0] ph,
                                          logic msb, i2cmbe_pkg::line_type ln,
                                          logic [15:0] u);
      enter_type r;
      logic [2:0] units;
      logic       b;
      r.lines = ln;
      r.dcnt  = '0;
      units   = 3'd0;
      b       = (cmd == i2cmbe_pkg::CMD_NACK);
      case (cmd)
         i2cmbe_pkg::CMD_START: begin
            if (ph == 3'd0) begin
               r.lines = '{1'b1, 1'b1, 1'b1}; units = 3'd4;
            end else if (ph == 3'd1) begin
               r.lines = '{1'b1, 1'b1, 1'b0}; units = 3'd4;
            end else begin
               r.lines = '{1'b0, 1'b1, 1'b0};
            end
         end
         i2cmbe_pkg::CMD_STOP: begin
            if (ph == 3'd0) begin
               r.lines = '{1'b0, 1'b1, 1'b0}; units = 3'd4;
            end else begin
               r.lines = '{1'b1, 1'b1, 1'b1};
               units   = (ph == 3'd1) ? 3'd4 : 3'd0;
            end
         end
         i2cmbe_pkg::CMD_WRITE: begin
            if (ph <= 3'd2) begin
               r.lines = '{(ph == 3'd1), 1'b1, msb}; units = 3'd2;
            end else begin
               r.lines = '{1'b0, 1'b1, ln.sda};
            end
         end
         i2cmbe_pkg::CMD_READ: begin
            if (ph == 3'd0) begin
               r.lines = '{1'b0, 1'b0, ln.sda}; units = 3'd2;
            end else if (ph == 3'd1) begin
               r.lines = '{1'b1, 1'b0, ln.sda}; units = 3'd1;
            end else begin
               r.lines = '{1'b1, 1'b0, ln.sda};
            end
         end
         i2cmbe_pkg::CMD_ACK, i2cmbe_pkg::CMD_NACK: begin
            if (ph == 3'd0) begin
               r.lines = '{1'b0, 1'b1, b}; units = 3'd2;
            end else if (ph == 3'd1) begin
               r.lines = '{1'b1, 1'b1, b}; units = 3'd2;
            end else begin
               r.lines = '{1'b0, 1'b1, b};
            end
         end
         default: begin
            if (ph == 3'd0) begin
               r.lines = '{ln.scl, 1'b0, ln.sda}; units = 3'd1;
            end else begin
               r.lines = '{1'b1, 1'b0, ln.sda};
               units   = (ph == 3'd1) ? 3'd1 : 3'd0;
            end
         end
      endcase
      case (units)
         3'd1:    r.dcnt = {2'b00, u};
         3'd2:    r.dcnt = {1'b0, u, 1'b0};
         3'd4:    r.dcnt = {u, 2'b00};
         default: r.dcnt = '0;
      endcase
      return r;
   endfunction

   assign unit = (delay_unit_ff == 16'd0) ? 16'd1 : delay_unit_ff;

   always_comb begin
      cmd_in     = cmd_ff;
      phase_in   = phase_ff;
      dcnt_in    = dcnt_ff;
      bcnt_in    = bcnt_ff;
      shift_in   = shift_ff;
      poll_in    = poll_ff;
      lines_in   = lines_ff;
      rx_in      = rx_ff;
      fail_in    = fail_ff;
      busy       = 1'b0;
      done       = 1'b0;
      next_phase = 3'd0;
      ent        = '0;

      // command launch on the same tick
      if (cmd_ff == i2cmbe_pkg::CMD_IDLE && action != i2cmbe_pkg::CMD_IDLE) begin
         cmd_in   = action;
         bcnt_in  = 4'd0;
         poll_in  = 8'd0;
         shift_in = (action == i2cmbe_pkg::CMD_WRITE) ? tx_byte : 8'd0;
         ent      = enter_fn(action, 3'd0, shift_in[7], lines_in, unit);
         phase_in = 3'd0;
         lines_in = ent.lines;
         dcnt_in  = ent.dcnt;
      end

      out_lines = lines_in;

      if (cmd_in != i2cmbe_pkg::CMD_IDLE) begin
         busy = 1'b1;
         if (phase_in == i2cmbe_pkg::PH_FINAL) begin
            done = 1'b1;
            if (cmd_in == i2cmbe_pkg::CMD_READ) begin
               rx_in = shift_in;
            end
            cmd_in   = i2cmbe_pkg::CMD_IDLE;
            phase_in = 3'd0;
         end else if (phase_in == i2cmbe_pkg::PH_POLL) begin
            if (!sda_level) begin
               lines_in  = '{1'b0, 1'b0, lines_in.sda};
               fail_in   = 1'b0;
               done      = 1'b1;
               cmd_in    = i2cmbe_pkg::CMD_IDLE;
               phase_in  = 3'd0;
               out_lines = lines_in;
            end else if (poll_in >= ack_timeout_ff) begin
               // timeout: fall into a stop sequence
               fail_in   = 1'b1;
               cmd_in    = i2cmbe_pkg::CMD_STOP;
               ent       = enter_fn(i2cmbe_pkg::CMD_STOP, 3'd0, shift_in[7], lines_in, unit);
               phase_in  = 3'd0;
               lines_in  = ent.lines;
               dcnt_in   = ent.dcnt - 18'd1;
               out_lines = lines_in;
            end else begin
               poll_in = poll_in + 8'd1;
            end
         end else begin
            if (cmd_in == i2cmbe_pkg::CMD_READ && phase_in == 3'd1
                && dcnt_in == {2'b00, unit}) begin
               shift_in = {shift_in[6:0], sda_level};
            end
            if (dcnt_in != 18'd0) begin
               dcnt_in = dcnt_in - 18'd1;
            end
            if (dcnt_in == 18'd0) begin
               case (cmd_in)
                  i2cmbe_pkg::CMD_WRITE: begin
                     if (phase_in == 3'd2) begin
                        shift_in   = {shift_in[6:0], 1'b0};
                        bcnt_in    = bcnt_in + 4'd1;
                        next_phase = bcnt_in[3] ? i2cmbe_pkg::PH_FINAL : 3'd0;
                     end else begin
                        next_phase = phase_in + 3'd1;
                     end
                  end
                  i2cmbe_pkg::CMD_READ: begin
                     if (phase_in == 3'd1) begin
                        bcnt_in    = bcnt_in + 4'd1;
                        next_phase = bcnt_in[3] ? i2cmbe_pkg::PH_FINAL : 3'd0;
                     end else begin
                        next_phase = 3'd1;
                     end
                  end
                  i2cmbe_pkg::CMD_WAIT: begin
                     next_phase = (phase_in == 3'd0) ? 3'd1 : i2cmbe_pkg::PH_POLL;
                  end
                  default: begin
                     next_phase = (phase_in == 3'd1) ? i2cmbe_pkg::PH_FINAL
                                                     : phase_in + 3'd1;
                  end
               endcase
               ent      = enter_fn(cmd_in, next_phase, shift_in[7], lines_in, unit);
               phase_in = next_phase;
               lines_in = ent.lines;
               dcnt_in  = ent.dcnt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_unit_ff  <= i2cmbe_pkg::DELAY_UNIT_RESET;
         ack_timeout_ff <= i2cmbe_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2cmbe_pkg::CSR_DELAY_UNIT:  delay_unit_ff  <= csr_wdata;
            i2cmbe_pkg::CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= i2cmbe_pkg::CMD_IDLE;
         phase_ff <= 3'd0;
         dcnt_ff  <= '0;
         bcnt_ff  <= '0;
         shift_ff <= '0;
         poll_ff  <= '0;
         lines_ff <= '{1'b1, 1'b1, 1'b1};
         rx_ff    <= '0;
         fail_ff  <= 1'b0;
      end else if (step) begin
         cmd_ff   <= cmd_in;
         phase_ff <= phase_in;
         dcnt_ff  <= dcnt_in;
         bcnt_ff  <= bcnt_in;
         shift_ff <= shift_in;
         poll_ff  <= poll_in;
         lines_ff <= lines_in;
         rx_ff    <= rx_in;
         fail_ff  <= fail_in;
      end
   end

   assign result = '{scl_level:  out_lines.scl,
                     sda_enable: out_lines.en,
                     sda_out:    out_lines.sda,
                     busy_res:   busy,
                     done_res:   done,
                     rx_byte:    rx_in,
                     ack_failed: fail_in};

endmodule

>>> hw/rtl/i2cmbe_out_reg.sv
// ----------------------------------------------------------------------------
// i2cmbe_out_reg
// Response output register; takes a new beat whenever it is empty or being
// drained in the same cycle.
// ----------------------------------------------------------------------------
module i2cmbe_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  i2cmbe_pkg::rsp_type load_data,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmbe_pkg::rsp_type rsp_data
);

   logic                valid_ff, valid_in;
   i2cmbe_pkg::rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> hw/rtl/i2c_master_bit_engine_unit.sv
// a response beat appears in the cycle after its request beat is accepted
// throughput: one request beat per cycle unless stalled; one sequencer tick per beat
// bus timing counts accepted beats, delay_unit beats per delay unit (0 counts as 1)
// reset: synchronous; sequencer idle, SCL high, SDA driven high, registers at defaults
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master bit engine: start, stop, byte write and read, ack, nack and wait-ack.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_sda_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_enable,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_failed,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic                step;
   i2cmbe_pkg::rsp_type core_result;
   i2cmbe_pkg::rsp_type out_data;

   assign step = req_valid && req_ready;

   i2cmbe_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .action    (i2cmbe_pkg::cmd_type'(req_action)),
      .tx_byte   (req_tx_byte),
      .sda_level (req_sda_level),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (core_result)
   );

   i2cmbe_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_data (core_result),
      .can_load  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_data)
   );

   assign rsp_scl_level  = out_data.scl_level;
   assign rsp_sda_enable = out_data.sda_enable;
   assign rsp_sda_out    = out_data.sda_out;
   assign rsp_busy_res   = out_data.busy_res;
   assign rsp_done_res   = out_data.done_res;
   assign rsp_rx_byte    = out_data.rx_byte;
   assign rsp_ack_failed = out_data.ack_failed;

endmodule

>>> hw/rtl/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks of the bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_scl_level,
   input logic        rsp_sda_enable,
   input logic        rsp_sda_out,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [7:0]  rsp_rx_byte,
   input logic        rsp_ack_failed
);

   // a finished command is always reported as busy on its done tick
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done beat without busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // only a full, stalled output register may hold off requests
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled with room in output register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_scl_level, rsp_sda_enable, rsp_sda_out, rsp_busy_res,
                     rsp_done_res, rsp_rx_byte, rsp_ack_failed}))
      else $error("stalled response beat changed");

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_i2cmbe_checker (.*);

>>> tb/i2c_master_bit_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit_tb
// Self-checking bench for the I2C master bit engine. A directed table walks
// every command, the timing register extremes and the ack timeout, then
// random command streams run under several timing settings. Every beat is
// predicted by a cycle model of the bus sequencer or set in the table, and
// checked on the response channel, with random backpressure on both sides in every random run but the last.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit_tb;

   localparam int unsigned CYCLE_LIMIT = 60000;
   localparam int RUN_PHASES = 3;
   localparam int RUN_BEATS = 28;
   localparam logic [15:0] RUN_UNITS [RUN_PHASES] = '{16'd2, 16'd0, 16'd1};
   localparam logic [15:0] RUN_POLLS [RUN_PHASES] = '{16'd3, 16'd0, 16'd1};

   localparam i2cmbe_pkg::rsp_type AT_RESET   = '{scl_level: 1'b1, sda_enable: 1'b1,
                                                  sda_out: 1'b1, busy_res: 1'b0,
                                                  done_res: 1'b0, rx_byte: 8'h00,
                                                  ack_failed: 1'b0};
   localparam i2cmbe_pkg::rsp_type START_OPEN = '{scl_level: 1'b1, sda_enable: 1'b1,
                                                  sda_out: 1'b1, busy_res: 1'b1,
                                                  done_res: 1'b0, rx_byte: 8'h00,
                                                  ack_failed: 1'b0};
   localparam i2cmbe_pkg::rsp_type START_NAKD = '{scl_level: 1'b1, sda_enable: 1'b1,
                                                  sda_out: 1'b1, busy_res: 1'b1,
                                                  done_res: 1'b0, rx_byte: 8'h00,
                                                  ack_failed: 1'b1};

   typedef struct {
      bit                  csr;
      logic                idx;
      logic [15:0]         val;
      i2cmbe_pkg::cmd_type act;
      logic [7:0]          tx;
      logic                sda;
      bit                  typed;
      i2cmbe_pkg::rsp_type want;
   } plan_row;

   // sda level of a command row is held for every tick of that command
   plan_row plan [24] = '{
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_IDLE,
        8'h00, 1'b0, 1'b1, AT_RESET},
      '{1'b1, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_IDLE,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_START,
        8'h00, 1'b0, 1'b1, START_OPEN},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_WRITE,
        8'hA5, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_WAIT,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_STOP,
        8'h00, 1'b1, 1'b0, '0},
      '{1'b1, i2cmbe_pkg::CSR_ACK_TIMEOUT, 16'd0, i2cmbe_pkg::CMD_IDLE,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_WAIT,
        8'h00, 1'b1, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_START,
        8'h00, 1'b1, 1'b1, START_NAKD},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_WRITE,
        8'h00, 1'b1, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_WRITE,
        8'hFF, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_WAIT,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_READ,
        8'h00, 1'b1, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_READ,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_ACK,
        8'h00, 1'b1, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_NACK,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_STOP,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b1, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd1, i2cmbe_pkg::CMD_IDLE,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b1, i2cmbe_pkg::CSR_ACK_TIMEOUT, 16'd255, i2cmbe_pkg::CMD_IDLE,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_WAIT,
        8'h00, 1'b1, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_READ,
        8'h00, 1'b1, 1'b0, '0},
      '{1'b1, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd2, i2cmbe_pkg::CMD_IDLE,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_WAIT,
        8'h00, 1'b0, 1'b0, '0},
      '{1'b0, i2cmbe_pkg::CSR_DELAY_UNIT, 16'd0, i2cmbe_pkg::CMD_IDLE,
        8'h3C, 1'b1, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = i2cmbe_pkg::CMD_IDLE;
   logic [7:0]  req_tx_byte = 8'h00;
   logic        req_sda_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_scl_level;
   logic        rsp_sda_enable;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_failed;
   logic        csr_we = 1'b0;
   logic        csr_index = i2cmbe_pkg::CSR_DELAY_UNIT;
   logic [15:0] csr_wdata = 16'h0000;

   // engine model state
   logic [15:0]          unit_cfg;
   logic [7:0]           timeout_cfg;
   i2cmbe_pkg::cmd_type  bus_cmd;
   logic [2:0]           bus_phase;
   logic [17:0]          tick_count;
   logic [3:0]           bits_done;
   logic [7:0]           shifter;
   logic [7:0]           polls;
   i2cmbe_pkg::line_type lines;
   logic [7:0]           last_rx;
   logic                 ack_fail;

   i2cmbe_pkg::rsp_type tick_status_due [$];
   bit          mismatch_seen = 1'b0;
   bit          sender_jitter = 1'b0;
   bit          sink_jitter = 1'b0;
   bit          hold_armed = 1'b0;
   bit          hold_taken = 1'b0;
   int          long_hold = 0;
   int          sink_stall = 0;
   int unsigned cycle_count = 0;

   i2c_master_bit_engine_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_tx_byte    (req_tx_byte),
      .req_sda_level  (req_sda_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_enable (rsp_sda_enable),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_ack_failed (rsp_ack_failed),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [17:0] unit_ticks();
      return (unit_cfg == 16'd0) ? 18'd1 : 18'(unit_cfg);
   endfunction

   function automatic void drive_lines(logic scl, logic en, logic sda);
      lines = '{scl: scl, en: en, sda: sda};
   endfunction

   function automatic void enter_phase(logic [2:0] p);
      int   units;
      logic b;
      units = 0;
      bus_phase = p;
      case (bus_cmd)
         i2cmbe_pkg::CMD_START: begin
            if (p == 3'd0) begin
               drive_lines(1'b1, 1'b1, 1'b1);
               units = 4;
            end else if (p == 3'd1) begin
               drive_lines(1'b1, 1'b1, 1'b0);
               units = 4;
            end else begin
               drive_lines(1'b0, 1'b1, 1'b0);
            end
         end
         i2cmbe_pkg::CMD_STOP: begin
            if (p == 3'd0) begin
               drive_lines(1'b0, 1'b1, 1'b0);
               units = 4;
            end else begin
               drive_lines(1'b1, 1'b1, 1'b1);
               units = (p == 3'd1) ? 4 : 0;
            end
         end
         i2cmbe_pkg::CMD_WRITE: begin
            b = shifter[7];
            if (p <= 3'd2) begin
               drive_lines(p == 3'd1, 1'b1, b);
               units = 2;
            end else begin
               drive_lines(1'b0, 1'b1, lines.sda);
            end
         end
         i2cmbe_pkg::CMD_READ: begin
            if (p == 3'd0) begin
               drive_lines(1'b0, 1'b0, lines.sda);
               units = 2;
            end else begin
               drive_lines(1'b1, 1'b0, lines.sda);
               units = (p == 3'd1) ? 1 : 0;
            end
         end
         i2cmbe_pkg::CMD_ACK, i2cmbe_pkg::CMD_NACK: begin
            b = (bus_cmd == i2cmbe_pkg::CMD_NACK);
            if (p <= 3'd1) begin
               drive_lines(p == 3'd1, 1'b1, b);
               units = 2;
            end else begin
               drive_lines(1'b0, 1'b1, b);
            end
         end
         default: begin
            // first unit of wait ack keeps scl where it was
            if (p == 3'd0) begin
               drive_lines(lines.scl, 1'b0, lines.sda);
               units = 1;
            end else begin
               drive_lines(1'b1, 1'b0, lines.sda);
               units = (p == 3'd1) ? 1 : 0;
            end
         end
      endcase
      tick_count = 18'(units * unit_ticks());
   endfunction

   function automatic void next_phase();
      case (bus_cmd)
         i2cmbe_pkg::CMD_WRITE: begin
            if (bus_phase == 3'd2) begin
               shifter = shifter << 1;
               bits_done = bits_done + 4'd1;
               enter_phase(bits_done >= 4'd8 ? i2cmbe_pkg::PH_FINAL : 3'd0);
            end else begin
               enter_phase(bus_phase + 3'd1);
            end
         end
         i2cmbe_pkg::CMD_READ: begin
            if (bus_phase == 3'd1) begin
               bits_done = bits_done + 4'd1;
               enter_phase(bits_done >= 4'd8 ? i2cmbe_pkg::PH_FINAL : 3'd0);
            end else begin
               enter_phase(3'd1);
            end
         end
         i2cmbe_pkg::CMD_WAIT: enter_phase(bus_phase == 3'd0 ? 3'd1 : i2cmbe_pkg::PH_POLL);
         default: enter_phase(bus_phase == 3'd1 ? i2cmbe_pkg::PH_FINAL : bus_phase + 3'd1);
      endcase
   endfunction

   function automatic void count_down();
      if (tick_count != 18'd0) tick_count = tick_count - 18'd1;
      if (tick_count == 18'd0) next_phase();
   endfunction

   function automatic void model_reset();
      unit_cfg = i2cmbe_pkg::DELAY_UNIT_RESET;
      timeout_cfg = i2cmbe_pkg::ACK_TIMEOUT_RESET;
      bus_cmd = i2cmbe_pkg::CMD_IDLE;
      bus_phase = 3'd0;
      tick_count = 18'd0;
      bits_done = 4'd0;
      shifter = 8'h00;
      polls = 8'h00;
      drive_lines(1'b1, 1'b1, 1'b1);
      last_rx = 8'h00;
      ack_fail = 1'b0;
   endfunction

   function automatic i2cmbe_pkg::rsp_type engine_tick(i2cmbe_pkg::cmd_type act,
                                                       logic [7:0] tx, logic sda_in);
      i2cmbe_pkg::rsp_type  r;
      i2cmbe_pkg::line_type shown;
      r = '0;
      if (bus_cmd == i2cmbe_pkg::CMD_IDLE && act != i2cmbe_pkg::CMD_IDLE) begin
         bus_cmd = act;
         bits_done = 4'd0;
         polls = 8'h00;
         shifter = (act == i2cmbe_pkg::CMD_WRITE) ? tx : 8'h00;
         enter_phase(3'd0);
      end
      shown = lines;
      if (bus_cmd != i2cmbe_pkg::CMD_IDLE) begin
         r.busy_res = 1'b1;
         if (bus_phase == i2cmbe_pkg::PH_FINAL) begin
            r.done_res = 1'b1;
            if (bus_cmd == i2cmbe_pkg::CMD_READ) last_rx = shifter;
            bus_cmd = i2cmbe_pkg::CMD_IDLE;
            bus_phase = 3'd0;
         end else if (bus_phase == i2cmbe_pkg::PH_POLL) begin
            if (!sda_in) begin
               drive_lines(1'b0, 1'b0, lines.sda);
               shown = lines;
               ack_fail = 1'b0;
               r.done_res = 1'b1;
               bus_cmd = i2cmbe_pkg::CMD_IDLE;
               bus_phase = 3'd0;
            end else if (polls >= timeout_cfg) begin
               // no ack in time: fall into a stop sequence
               ack_fail = 1'b1;
               bus_cmd = i2cmbe_pkg::CMD_STOP;
               enter_phase(3'd0);
               shown = lines;
               count_down();
            end else begin
               polls = polls + 8'd1;
            end
         end else begin
            if (bus_cmd == i2cmbe_pkg::CMD_READ && bus_phase == 3'd1
                && tick_count == unit_ticks())
               shifter = {shifter[6:0], sda_in};
            count_down();
         end
      end
      r.scl_level = shown.scl;
      r.sda_enable = shown.en;
      r.sda_out = shown.sda;
      r.rx_byte = last_rx;
      r.ack_failed = ack_fail;
      return r;
   endfunction

   task automatic send_beat(input i2cmbe_pkg::cmd_type act, input logic [7:0] tx,
                            input logic sda, input bit typed = 1'b0,
                            input i2cmbe_pkg::rsp_type want = '0);
      i2cmbe_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_action <= act;
      req_tx_byte <= tx;
      req_sda_level <= sda;
      do @(posedge clock); while (!req_ready);
      predicted = engine_tick(act, tx, sda);
      tick_status_due.push_back(typed ? want : predicted);
      if (sender_jitter && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      req_valid <= 1'b0;
      while (tick_status_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == i2cmbe_pkg::CSR_DELAY_UNIT) unit_cfg = val;
      else timeout_cfg = val[7:0];
      csr_we <= 1'b0;
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      i2cmbe_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tick_status_due.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            mismatch_seen = 1'b1;
         end else begin
            want = tick_status_due.pop_front();
            check_field("scl_level", 8'(want.scl_level), 8'(rsp_scl_level));
            check_field("sda_enable", 8'(want.sda_enable), 8'(rsp_sda_enable));
            check_field("sda_out", 8'(want.sda_out), 8'(rsp_sda_out));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
            check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
            check_field("rx_byte", want.rx_byte, rsp_rx_byte);
            check_field("ack_failed", 8'(want.ack_failed), 8'(rsp_ack_failed));
         end
      end
   end

   // response side backpressure, one long hold early in the random part
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (long_hold != 0) begin
         rsp_ready <= 1'b0;
         long_hold <= long_hold - 1;
      end else if (hold_armed && !hold_taken) begin
         rsp_ready <= 1'b0;
         long_hold <= 59;
         hold_taken <= 1'b1;
      end else if (sink_stall != 0) begin
         rsp_ready <= 1'b0;
         sink_stall <= sink_stall - 1;
      end else if (sink_jitter && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         sink_stall <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("i2c_master_bit_engine_unit: mismatch");
         $finish;
      end
   end

   initial begin
      i2cmbe_pkg::cmd_type act;
      int                  issued;
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].csr) begin
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            send_beat(plan[i].act, plan[i].tx, plan[i].sda, plan[i].typed, plan[i].want);
            while (bus_cmd != i2cmbe_pkg::CMD_IDLE)
               send_beat(i2cmbe_pkg::CMD_IDLE, plan[i].tx, plan[i].sda);
         end
      end

      for (int ph = 0; ph < RUN_PHASES; ph++) begin
         write_reg(i2cmbe_pkg::CSR_DELAY_UNIT, RUN_UNITS[ph]);
         write_reg(i2cmbe_pkg::CSR_ACK_TIMEOUT, RUN_POLLS[ph]);
         sender_jitter = (ph != RUN_PHASES - 1);
         sink_jitter = (ph != RUN_PHASES - 1);
         if (ph == 0) hold_armed = 1'b1;
         issued = 0;
         while (issued < RUN_BEATS || bus_cmd != i2cmbe_pkg::CMD_IDLE) begin
            if (bus_cmd == i2cmbe_pkg::CMD_IDLE) begin
               act = ($urandom_range(0, 4) != 0) ? i2cmbe_pkg::cmd_type'($urandom_range(1, 7))
                                                 : i2cmbe_pkg::CMD_IDLE;
            end else begin
               // ignored while a command runs
               act = i2cmbe_pkg::cmd_type'($urandom_range(0, 7));
            end
            send_beat(act, 8'($urandom), $urandom_range(0, 3) != 0);
            issued++;
         end
      end

      req_valid <= 1'b0;
      while (tick_status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (!mismatch_seen)
         $display("i2c_master_bit_engine_unit: match");
      else
         $display("i2c_master_bit_engine_unit: mismatch");
      $finish;
   end

endmodule
